// ----- design/trmc_pkg.sv -----
// Shared types and constants for the tiled radius match counter.
`timescale 1ns / 1ps
package trmc_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int SQ_W    = 50;
	localparam int QID_W   = 10;
	localparam int PID_W   = 24;
	localparam int CNT_W   = 25;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	typedef enum logic [1:0] {
		FN_CLEAR = 2'd0,
		FN_LOAD  = 2'd1,
		FN_TEST  = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic        [QID_W-1:0]   id;
	} tile_entry_t;

	typedef struct packed {
		logic  ld;
		logic  sq_en;
		axis_t sel;
		logic  acc_ld;
		logic  acc_add;
	} dist_ctl_t;

endpackage

// ----- design/trmc_tile_mem.sv -----
// Query tile storage: one write port, one registered read port.
`timescale 1ns / 1ps
module trmc_tile_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         wa,
	input  trmc_pkg::tile_entry_t wd,
	input  logic                  re,
	input  logic [AW-1:0]         ra,
	output trmc_pkg::tile_entry_t rd
);
	import trmc_pkg::*;

	tile_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

// ----- design/trmc_count_mem.sv -----
// Per-query match count storage: one write port, one registered read port.
`timescale 1ns / 1ps
module trmc_count_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              wa,
	input  logic [trmc_pkg::CNT_W-1:0] wd,
	input  logic                       re,
	input  logic [AW-1:0]              ra,
	output logic [trmc_pkg::CNT_W-1:0] rd
);
	import trmc_pkg::*;

	logic [CNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

// ----- design/trmc_dist_unit.sv -----
// Shared squared-distance unit: one squarer, one accumulator, one compare.
`timescale 1ns / 1ps
module trmc_dist_unit (
	input  logic                                clk,
	input  trmc_pkg::dist_ctl_t                 ctl,
	input  logic signed [trmc_pkg::COORD_W-1:0] pt_x,
	input  logic signed [trmc_pkg::COORD_W-1:0] pt_y,
	input  logic signed [trmc_pkg::COORD_W-1:0] pt_z,
	input  trmc_pkg::tile_entry_t               ent,
	input  logic        [trmc_pkg::SQ_W-1:0]    radius,
	output logic                                hit
);
	import trmc_pkg::*;

	logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic signed [DIFF_W-1:0] d;
	logic signed [SQ_W-1:0]   p;
	logic        [SQ_W-1:0]   prod_q;
	logic        [SQ_W-1:0]   acc_q;

	always_comb begin
		case (ctl.sel)
			AX_X:    d = dx_q;
			AX_Y:    d = dy_q;
			AX_Z:    d = dz_q;
			default: d = dx_q;
		endcase
	end

	assign p = d * d;

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			dx_q <= {pt_x[COORD_W-1], pt_x} - {ent.x[COORD_W-1], ent.x};
			dy_q <= {pt_y[COORD_W-1], pt_y} - {ent.y[COORD_W-1], ent.y};
			dz_q <= {pt_z[COORD_W-1], pt_z} - {ent.z[COORD_W-1], ent.z};
		end
		if (ctl.sq_en) begin
			prod_q <= p;
		end
		if (ctl.acc_ld) begin
			acc_q <= prod_q;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	// Three squares stay below 2^50, so the sum is exact in SQ_W bits.
	assign hit = (acc_q + prod_q) <= radius;

endmodule

// ----- design/tiled_radius_match_counter_unit.sv -----
// Top level of the tiled radius match counter: sequencer, registers and outputs.
`timescale 1ns / 1ps
// Clear tile and load query leave busy low, and no result follows.
// Read count: busy in ST_CREP, which zeroes a valid id's count and registers the reply.
// Test candidate: busy in RD, DIFF, M0-M2 and CMP per entry, CNT per match, then END
// (not busy on an empty tile); one shared squarer makes three squares per query; a
// report waits for the next match or the end. Reset clears control state at once, then
// a pass zeroes all QUERY_MAX counts, one per cycle with busy high. Results cannot be stalled.
module tiled_radius_match_counter_unit #(
	parameter int TILE_DEPTH = 32,
	parameter int QUERY_MAX  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          func,
	input  logic signed [trmc_pkg::COORD_W-1:0] coord_x,
	input  logic signed [trmc_pkg::COORD_W-1:0] coord_y,
	input  logic signed [trmc_pkg::COORD_W-1:0] coord_z,
	input  logic        [trmc_pkg::QID_W-1:0]   query_id,
	input  logic        [trmc_pkg::PID_W-1:0]   point_id,
	// result channel
	output logic                                result_valid,
	output logic                                kind,
	output logic        [trmc_pkg::QID_W-1:0]   match_query,
	output logic        [trmc_pkg::PID_W-1:0]   match_point,
	output logic        [trmc_pkg::CNT_W-1:0]   rank_or_count,
	output logic                                last,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);
	import trmc_pkg::*;

	localparam int TW   = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
	localparam int FW   = $clog2(TILE_DEPTH + 1);
	localparam int QA_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

	typedef enum logic [10:0] {
		ST_CLR  = 11'b000_0000_0001,
		ST_IDLE = 11'b000_0000_0010,
		ST_CREP = 11'b000_0000_0100,
		ST_RD   = 11'b000_0000_1000,
		ST_DIFF = 11'b000_0001_0000,
		ST_M0   = 11'b000_0010_0000,
		ST_M1   = 11'b000_0100_0000,
		ST_M2   = 11'b000_1000_0000,
		ST_CMP  = 11'b001_0000_0000,
		ST_CNT  = 11'b010_0000_0000,
		ST_END  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SQ_W-1:0] radius_q;
	logic            emit_q;

	// Sequencer registers.
	logic [QA_W-1:0]  clr_idx_q;
	logic [FW-1:0]    fill_q;
	logic [TW-1:0]    idx_q;
	logic [QID_W-1:0] id_q;
	logic [QID_W-1:0] rq_id_q;
	logic             rq_ok_q;

	// Latched candidate.
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic        [PID_W-1:0]   pid_q;

	// Match held back until it is known whether another follows.
	logic             pend_v_q;
	logic [QID_W-1:0] pend_id_q;
	logic [CNT_W-1:0] pend_rank_q;

	// Output registers.
	logic             res_v_q;
	logic             kind_q;
	logic [QID_W-1:0] mq_q;
	logic [PID_W-1:0] mp_q;
	logic [CNT_W-1:0] rc_q;
	logic             last_q;

	logic        accept;
	func_t       fn;
	logic        qid_ok;
	logic        tile_room;
	logic        last_ent;
	logic        hit;
	logic        cfg_wr;
	tile_entry_t tm_wd, tm_rd;
	logic        tm_we, tm_re;
	dist_ctl_t   dctl;
	logic            cm_we, cm_re;
	logic [QA_W-1:0] cm_wa, cm_ra;
	logic [CNT_W-1:0] cm_wd, cm_rd;
	logic [CNT_W-1:0] rank_next;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign fn        = func_t'(func);
	assign qid_ok    = 32'(query_id) < QUERY_MAX;
	assign tile_room = fill_q < FW'(TILE_DEPTH);
	assign last_ent  = (FW'(idx_q) + FW'(1)) == fill_q;
	assign rank_next = (cm_rd == COUNT_MAX) ? cm_rd : cm_rd + CNT_W'(1);

	// APB: radius at 0x0, emit flag at 0x8; decode on paddr[3] only.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[3] ? {63'd0, emit_q} : {{(64 - SQ_W){1'b0}}, radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			emit_q   <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				emit_q <= pwdata[0];
			end else begin
				radius_q <= pwdata[SQ_W-1:0];
			end
		end
	end

	// Tile store: write on an accepted load with room and a valid query id, read one entry per comparison.
	assign tm_we    = accept && (fn == FN_LOAD) && tile_room && qid_ok;
	assign tm_wd.x  = coord_x;
	assign tm_wd.y  = coord_y;
	assign tm_wd.z  = coord_z;
	assign tm_wd.id = query_id;
	assign tm_re    = (state_q == ST_RD);

	trmc_tile_mem #(
		.DEPTH (TILE_DEPTH),
		.AW    (TW)
	) u_tile (
		.clk (clk),
		.we  (tm_we),
		.wa  (fill_q[TW-1:0]),
		.wd  (tm_wd),
		.re  (tm_re),
		.ra  (idx_q),
		.rd  (tm_rd)
	);

	// Drive the shared squarer: diffs, then x^2, y^2, z^2 in turn.
	always_comb begin
		dctl.ld      = (state_q == ST_DIFF);
		dctl.sq_en   = (state_q == ST_M0) || (state_q == ST_M1) || (state_q == ST_M2);
		dctl.acc_ld  = (state_q == ST_M1);
		dctl.acc_add = (state_q == ST_M2);
		case (state_q)
			ST_M1:   dctl.sel = AX_Y;
			ST_M2:   dctl.sel = AX_Z;
			default: dctl.sel = AX_X;
		endcase
	end

	trmc_dist_unit u_dist (
		.clk    (clk),
		.ctl    (dctl),
		.pt_x   (px_q),
		.pt_y   (py_q),
		.pt_z   (pz_q),
		.ent    (tm_rd),
		.radius (radius_q),
		.hit    (hit)
	);

	// Count store ports: clear pass, count reply, and match increment.
	always_comb begin
		cm_we = 1'b0;
		cm_wa = '0;
		cm_wd = '0;
		cm_re = 1'b0;
		cm_ra = '0;
		case (state_q)
			ST_CLR: begin
				cm_we = 1'b1;
				cm_wa = clr_idx_q;
			end
			ST_IDLE: begin
				cm_re = start && (fn == FN_READ) && qid_ok;
				cm_ra = QA_W'(query_id);
			end
			ST_CREP: begin
				cm_we = rq_ok_q;
				cm_wa = QA_W'(rq_id_q);
			end
			ST_CMP: begin
				cm_re = hit;
				cm_ra = QA_W'(id_q);
			end
			ST_CNT: begin
				cm_we = 1'b1;
				cm_wa = QA_W'(id_q);
				cm_wd = rank_next;
			end
			default: begin
				cm_we = 1'b0;
			end
		endcase
	end

	trmc_count_mem #(
		.DEPTH (QUERY_MAX),
		.AW    (QA_W)
	) u_count (
		.clk (clk),
		.we  (cm_we),
		.wa  (cm_wa),
		.wd  (cm_wd),
		.re  (cm_re),
		.ra  (cm_ra),
		.rd  (cm_rd)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_idx_q <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			pend_v_q  <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					// Sweep the count store once, one entry per cycle.
					clr_idx_q <= clr_idx_q + QA_W'(1);
					if (clr_idx_q == QA_W'(QUERY_MAX - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (fn)
							FN_CLEAR: fill_q <= '0;
							FN_LOAD: begin
								if (tile_room && qid_ok) begin
									fill_q <= fill_q + FW'(1);
								end
							end
							FN_TEST: begin
								idx_q <= '0;
								if (fill_q != '0) begin
									state_q <= ST_RD;
								end
							end
							FN_READ: state_q <= ST_CREP;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CREP: begin
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD:   state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_CMP;
				ST_CMP: begin
					if (hit) begin
						state_q <= ST_CNT;
					end else if (last_ent) begin
						state_q <= ST_END;
					end else begin
						idx_q   <= idx_q + TW'(1);
						state_q <= ST_RD;
					end
				end
				ST_CNT: begin
					// With emit set, release the held match and hold the new one in its place.
					if (emit_q) begin
						res_v_q  <= pend_v_q;
						pend_v_q <= 1'b1;
					end
					if (last_ent) begin
						state_q <= ST_END;
					end else begin
						idx_q   <= idx_q + TW'(1);
						state_q <= ST_RD;
					end
				end
				ST_END: begin
					res_v_q  <= pend_v_q;
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= coord_x;
			py_q    <= coord_y;
			pz_q    <= coord_z;
			pid_q   <= point_id;
			rq_id_q <= query_id;
			rq_ok_q <= qid_ok;
		end
		if (state_q == ST_DIFF) begin
			id_q <= tm_rd.id;
		end
		case (state_q)
			ST_CREP: begin
				kind_q <= KIND_COUNT;
				mq_q   <= rq_id_q;
				mp_q   <= '0;
				rc_q   <= rq_ok_q ? cm_rd : '0;
				last_q <= 1'b1;
			end
			ST_CNT: begin
				kind_q      <= KIND_MATCH;
				mq_q        <= pend_id_q;
				mp_q        <= pid_q;
				rc_q        <= pend_rank_q;
				last_q      <= 1'b0;
				pend_id_q   <= id_q;
				pend_rank_q <= cm_rd;
			end
			ST_END: begin
				kind_q <= KIND_MATCH;
				mq_q   <= pend_id_q;
				mp_q   <= pid_q;
				rc_q   <= pend_rank_q;
				last_q <= 1'b1;
			end
			default: begin
				kind_q <= kind_q;
			end
		endcase
	end

	assign result_valid  = res_v_q;
	assign kind          = kind_q;
	assign match_query   = mq_q;
	assign match_point   = mp_q;
	assign rank_or_count = rc_q;
	assign last          = last_q;

	// A held match is always released before the sequencer goes idle.
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> busy)
		else $error("held match survived into idle");

	// A count reply is a single result with no point id.
	a_reply_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_COUNT) |-> (last && match_point == '0))
		else $error("malformed count reply");

	// The increment step only follows a distance compare.
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CNT) |-> $past(state_q == ST_CMP))
		else $error("count update without compare");

	// The tile never holds more than its depth.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TILE_DEPTH))
		else $error("tile fill beyond depth");

endmodule
